@@ rtl/lbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared types and codes for the buffer cache controller and datapath.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  localparam logic [2:0] REQ_GET     = 3'd0;
  localparam logic [2:0] REQ_RELEASE = 3'd1;
  localparam logic [2:0] REQ_PIN     = 3'd2;
  localparam logic [2:0] REQ_UNPIN   = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_COUNT  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  slot_index;
  } lbbc_in_t;

  typedef struct packed {
    logic [4:0] slot_out;
    logic       was_hit;
    logic       needs_read;
    logic [1:0] status;
  } lbbc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_OUT
  } lbbc_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic read_slot;
    logic exec;
  } lbbc_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lbbc_stat_t;

endpackage

@@ rtl/lbbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbbc_ctrl
// Sequencer for request load, slot scan, single-slot read, update and output.
// ----------------------------------------------------------------------------
module lbbc_ctrl import lbbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lbbc_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lbbc_cmd_t  cmd,
  input  lbbc_stat_t stat
);

  lbbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_data.req_type == REQ_GET) begin
            cmd.scan_start = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_READ: begin
        cmd.read_slot = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/lbbc_dp.sv @@
// ----------------------------------------------------------------------------
// lbbc_dp
// Slot tables, sequential tag and age scan, count and time update.
// ----------------------------------------------------------------------------
module lbbc_dp import lbbc_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lbbc_in_t   in_data,
  input  lbbc_cmd_t  cmd,
  output lbbc_stat_t stat,
  output lbbc_out_t  out_data
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic [7:0]  tag_dev_r  [NUM_SLOTS];
  logic [31:0] tag_blk_r  [NUM_SLOTS];
  logic [7:0]  cnt_r      [NUM_SLOTS];
  logic [31:0] time_r     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic [NUM_SLOTS-1:0] init_r;
  logic [31:0] tick_r;

  lbbc_in_t    req_r;
  logic [CW-1:0] idx_r;
  logic        hit_r, found_r;
  logic [IW-1:0] hit_idx_r, best_idx_r;
  logic [31:0] best_time_r;
  logic        slot_ok_r;
  logic [7:0]  rcnt_r;
  logic        rvalid_r;
  lbbc_out_t   out_r, out_nxt;

  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic          rd_init_r, rd_valid_r;
  logic [7:0]    rd_dev_r, rd_cnt_r;
  logic [31:0]   rd_blk_r, rd_time_r;

  logic [IW-1:0] ci, ra;
  logic [7:0]  c_dev, c_cnt;
  logic [31:0] c_blk, c_time;
  logic        cnt_err;

  logic [IW-1:0] sel;
  logic          sel_ok;
  logic [31:0]   sidx;
  always_comb begin
    sidx   = {27'd0, req_r.slot_index};
    sel_ok = (sidx < 32'(NUM_SLOTS));
    sel    = IW'(req_r.slot_index);
  end

  assign ci     = idx_r[IW-1:0];
  assign ra     = cmd.scan_step ? ci : sel;
  assign c_dev  = rd_init_r ? rd_dev_r  : 8'd0;
  assign c_blk  = rd_init_r ? rd_blk_r  : 32'd0;
  assign c_cnt  = rd_init_r ? rd_cnt_r  : 8'd0;
  assign c_time = rd_init_r ? rd_time_r : 32'd0;

  assign cnt_err = (req_r.req_type == REQ_PIN) ? (c_cnt == 8'hFF) : (c_cnt == 8'd0);

  assign stat.scan_done = hit_r || (rd_vld_r && rd_idx_r == IW'(NUM_SLOTS - 1));
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_step || cmd.read_slot) begin
      rd_dev_r   <= tag_dev_r[ra];
      rd_blk_r   <= tag_blk_r[ra];
      rd_cnt_r   <= cnt_r[ra];
      rd_time_r  <= time_r[ra];
      rd_init_r  <= init_r[ra];
      rd_valid_r <= valid_r[ra];
      rd_idx_r   <= ra;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.scan_start) begin
      idx_r    <= '0;
      hit_r    <= 1'b0;
      found_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r    <= idx_r + CW'(1);
      rd_vld_r <= 1'b1;
      if (rd_vld_r && !hit_r) begin
        if (c_dev == req_r.device_id && c_blk == req_r.block_number) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
          rcnt_r    <= c_cnt;
          rvalid_r  <= rd_valid_r;
        end else if (c_cnt == 8'd0 && (!found_r || c_time < best_time_r)) begin
          found_r     <= 1'b1;
          best_idx_r  <= rd_idx_r;
          best_time_r <= c_time;
        end
      end
    end
    if (cmd.read_slot) begin
      slot_ok_r <= sel_ok;
    end
  end

  always_comb begin
    out_nxt = '0;
    case (req_r.req_type)
      REQ_GET: begin
        if (hit_r) begin
          out_nxt.slot_out = 5'(hit_idx_r);
          out_nxt.was_hit  = 1'b1;
          if (rcnt_r == 8'hFF) begin
            out_nxt.status = ST_COUNT;
          end else begin
            out_nxt.needs_read = !rvalid_r;
          end
        end else if (!found_r) begin
          out_nxt.status = ST_NOFREE;
        end else begin
          out_nxt.slot_out   = 5'(best_idx_r);
          out_nxt.needs_read = 1'b1;
        end
      end
      REQ_RELEASE, REQ_PIN, REQ_UNPIN: begin
        out_nxt.slot_out = req_r.slot_index;
        if (slot_ok_r && cnt_err) begin
          out_nxt.status = ST_COUNT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      init_r  <= '0;
      tick_r  <= '0;
    end else if (cmd.exec) begin
      out_r <= out_nxt;
      case (req_r.req_type)
        REQ_GET: begin
          if (hit_r) begin
            if (rcnt_r != 8'hFF) begin
              if (!init_r[hit_idx_r]) begin
                tag_dev_r[hit_idx_r] <= 8'd0;
                tag_blk_r[hit_idx_r] <= 32'd0;
              end
              init_r[hit_idx_r]  <= 1'b1;
              cnt_r[hit_idx_r]   <= rcnt_r + 8'd1;
              time_r[hit_idx_r]  <= tick_r;
              valid_r[hit_idx_r] <= 1'b1;
            end
          end else if (found_r) begin
            if (!init_r[best_idx_r]) begin
              time_r[best_idx_r] <= 32'd0;
            end
            init_r[best_idx_r]    <= 1'b1;
            tag_dev_r[best_idx_r] <= req_r.device_id;
            tag_blk_r[best_idx_r] <= req_r.block_number;
            cnt_r[best_idx_r]     <= 8'd1;
            valid_r[best_idx_r]   <= 1'b1;
          end
        end
        REQ_TICK: begin
          tick_r <= tick_r + 32'd1;
        end
        REQ_RELEASE, REQ_PIN, REQ_UNPIN: begin
          if (slot_ok_r && !cnt_err) begin
            if (req_r.req_type == REQ_PIN) begin
              cnt_r[sel] <= c_cnt + 8'd1;
            end else begin
              cnt_r[sel] <= c_cnt - 8'd1;
            end
            if (req_r.req_type == REQ_RELEASE && c_cnt == 8'd1) begin
              time_r[sel] <= tick_r;
            end else if (!rd_init_r) begin
              time_r[sel] <= 32'd0;
            end
            if (!rd_init_r) begin
              tag_dev_r[sel] <= 8'd0;
              tag_blk_r[sel] <= 32'd0;
              init_r[sel]    <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/lru_block_buffer_cache.sv @@
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Buffer slot table with full tag search and least-recently-used recycling.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    lbbc_in_t  in_data
// out      output     out_valid / out_ready  lbbc_out_t out_data
//
// A get scans the table one slot per cycle over registered table reads and
// ends early on a tag hit. Other requests read a single slot instead of scanning.
// One item is in flight at a time.
// Reset clears all slots at once through per-slot init bits.
// The result is held in out_data until out_ready is seen.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache import lbbc_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lbbc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lbbc_out_t out_data
);

  lbbc_cmd_t  cmd;
  lbbc_stat_t stat;

  lbbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  lbbc_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .stat(stat), .out_data(out_data)
  );

endmodule
